// ----- rtl/tdc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants of the token denylist cache.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int OPCODE_W = 3;
  localparam int KEY_W    = 64;
  localparam int TTL_W    = 31;
  localparam int CAP_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int STAT_W   = 32;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TTL = 1'b0;
  localparam logic REG_CAP = 1'b1;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1000);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUT    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INVAL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

  // Verdict of the slot evaluator for one stored slot.
  typedef struct packed {
    logic valid;
    logic match;
    logic expired;
  } slot_eval_t;

endpackage

// ----- rtl/tdc_if.sv -----
// ----------------------------------------------------------------------------
// tdc_in_if / tdc_out_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface tdc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tdc_pkg::OPCODE_W-1:0]   opcode;
  logic [tdc_pkg::KEY_W-1:0]      token_key;
  logic                           revoked_in;

  modport source (output valid, opcode, token_key, revoked_in, input ready);
  modport sink   (input valid, opcode, token_key, revoked_in, output ready);
endinterface

interface tdc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic                           revoked_out;
  logic                           dropped;
  logic [tdc_pkg::COUNT_W-1:0]    entry_count;
  logic [tdc_pkg::STAT_W-1:0]     hit_total;
  logic [tdc_pkg::STAT_W-1:0]     miss_total;
  logic [tdc_pkg::STAT_W-1:0]     purge_total;
  logic [tdc_pkg::STAT_W-1:0]     drop_total;

  modport source (output valid, hit, revoked_out, dropped, entry_count, hit_total,
                  miss_total, purge_total, drop_total, input ready);
  modport sink   (input valid, hit, revoked_out, dropped, entry_count, hit_total,
                  miss_total, purge_total, drop_total, output ready);
endinterface

// ----- rtl/tdc_ram.sv -----
// ----------------------------------------------------------------------------
// tdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tdc_slot_eval.sv -----
// ----------------------------------------------------------------------------
// tdc_slot_eval
// Shared key-compare and age-compare unit applied to one slot per cycle.
// ----------------------------------------------------------------------------
module tdc_slot_eval #(
  parameter int TIME_BITS = 32
) (
  input  logic                          slot_valid_i,
  input  logic [tdc_pkg::KEY_W-1:0]     slot_key_i,
  input  logic [TIME_BITS-1:0]          slot_stamp_i,
  input  logic [tdc_pkg::KEY_W-1:0]     search_key_i,
  input  logic [TIME_BITS-1:0]          now_i,
  input  logic [tdc_pkg::TTL_W-1:0]     ttl_i,
  output tdc_pkg::slot_eval_t           eval_o
);
  import tdc_pkg::*;

  localparam int AGE_W = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;

  logic [TIME_BITS-1:0] age;

  // The age wraps with the time counter.
  assign age = now_i - slot_stamp_i;

  assign eval_o.valid   = slot_valid_i;
  assign eval_o.match   = slot_valid_i && (slot_key_i == search_key_i);
  assign eval_o.expired = AGE_W'(age) >= AGE_W'(ttl_i);

endmodule

// ----- rtl/ttl_denylist_cache.sv -----
// ----------------------------------------------------------------------------
// ttl_denylist_cache: one slot is read per cycle through the slot RAM port and
// the shared evaluator; a put on a full table first sweeps out expired slots,
// then searches for its key or a free slot and writes. After reset a clearing
// pass over every slot runs before the first item is taken.
// ----------------------------------------------------------------------------
module ttl_denylist_cache #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tdc_in_if.sink                        in_i,
  tdc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdc_pkg::APB_AW-1:0]    paddr,
  input  logic [tdc_pkg::APB_DW-1:0]    pwdata,
  output logic [tdc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import tdc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = 1 + TIME_BITS + KEY_W;
  localparam logic [AW:0] LAST_SLOT = (AW + 1)'(ENTRIES - 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOOKUP = 4'd2;
  localparam logic [3:0] ST_SWEEP  = 4'd3;
  localparam logic [3:0] ST_CHECK  = 4'd4;
  localparam logic [3:0] ST_FIND   = 4'd5;
  localparam logic [3:0] ST_WRITE  = 4'd6;
  localparam logic [3:0] ST_INVAL  = 4'd7;
  localparam logic [3:0] ST_CLEAR  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // Configuration registers.
  logic [TTL_W-1:0] ttl_q;
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;

  // Sequencer state.
  logic [3:0]           state_q, state_d;
  logic [AW:0]          scan_q, scan_d;
  logic                 evl_q, evl_d;
  logic [AW-1:0]        eval_addr_q, eval_addr_d;
  logic                 free_found_q, free_found_d;
  logic [AW-1:0]        free_addr_q, free_addr_d;
  logic [AW-1:0]        tgt_addr_q, tgt_addr_d;
  logic                 tgt_new_q, tgt_new_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CW-1:0]        valid_count_q, valid_count_d;
  logic [STAT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [STAT_W-1:0]    miss_cnt_q, miss_cnt_d;
  logic [STAT_W-1:0]    purge_cnt_q, purge_cnt_d;
  logic [STAT_W-1:0]    drop_cnt_q, drop_cnt_d;
  logic                 hit_q, hit_d;
  logic                 rev_out_q, rev_out_d;
  logic                 drop_q, drop_d;

  // Item payload.
  logic [KEY_W-1:0]     key_q;
  logic                 rev_in_q;

  // Result register.
  logic                 out_vld_q, out_vld_d;
  logic                 out_load;
  logic                 out_hit_q, out_rev_q, out_drop_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic [STAT_W-1:0]    out_hit_tot_q, out_miss_tot_q, out_purge_tot_q, out_drop_tot_q;

  // Slot storage.
  logic                 vram_we;
  logic [AW-1:0]        vram_waddr;
  logic [0:0]           vram_wdata;
  logic [0:0]           vram_rdata;
  logic                 dram_we;
  logic [DW-1:0]        dram_wdata;
  logic [DW-1:0]        dram_rdata;
  logic [AW-1:0]        rd_addr;
  logic                 issue;
  logic                 eval_last;
  logic                 full;
  slot_eval_t           ev;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TTL: ttl_q <= pwdata[TTL_W-1:0];
        REG_CAP: cap_q <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TTL: prdata = APB_DW'(ttl_q);
      REG_CAP: prdata = APB_DW'(cap_q);
      default: prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Slot storage and evaluator
  // --------------------------------------------------------------------------
  assign rd_addr    = scan_q[AW-1:0];
  assign dram_wdata = {rev_in_q, now_q, key_q};

  tdc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (vram_rdata)
  );

  tdc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (tgt_addr_q),
    .wdata_i (dram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dram_rdata)
  );

  tdc_slot_eval #(.TIME_BITS(TIME_BITS)) u_slot_eval (
    .slot_valid_i (vram_rdata[0]),
    .slot_key_i   (dram_rdata[KEY_W-1:0]),
    .slot_stamp_i (dram_rdata[KEY_W +: TIME_BITS]),
    .search_key_i (key_q),
    .now_i        (now_q),
    .ttl_i        (ttl_q),
    .eval_o       (ev)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign issue     = scan_q <= LAST_SLOT;
  assign eval_last = eval_addr_q == LAST_SLOT[AW-1:0];
  assign full      = (32'(valid_count_q) >= 32'(cap_q)) ||
                     (32'(valid_count_q) >= 32'(ENTRIES));
  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);
  assign in_i.ready = state_q == ST_IDLE;

  always_comb begin
    state_d       = state_q;
    scan_d        = scan_q;
    evl_d         = evl_q;
    eval_addr_d   = eval_addr_q;
    free_found_d  = free_found_q;
    free_addr_d   = free_addr_q;
    tgt_addr_d    = tgt_addr_q;
    tgt_new_d     = tgt_new_q;
    now_d         = now_q;
    valid_count_d = valid_count_q;
    hit_cnt_d     = hit_cnt_q;
    miss_cnt_d    = miss_cnt_q;
    purge_cnt_d   = purge_cnt_q;
    drop_cnt_d    = drop_cnt_q;
    hit_d         = hit_q;
    rev_out_d     = rev_out_q;
    drop_d        = drop_q;
    vram_we       = 1'b0;
    vram_waddr    = eval_addr_q;
    vram_wdata    = 1'b0;
    dram_we       = 1'b0;

    // Scanning states read one slot per cycle; its verdict comes from the registered RAM data.
    if (state_q == ST_LOOKUP || state_q == ST_SWEEP ||
        state_q == ST_FIND || state_q == ST_INVAL) begin
      evl_d       = issue;
      eval_addr_d = rd_addr;
      if (issue) begin
        scan_d = scan_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = rd_addr;
        if (scan_q == LAST_SLOT) begin
          valid_count_d = '0;
          state_d       = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_i.valid) begin
          hit_d        = 1'b0;
          rev_out_d    = 1'b0;
          drop_d       = 1'b0;
          scan_d       = '0;
          evl_d        = 1'b0;
          free_found_d = 1'b0;
          unique case (in_i.opcode)
            OP_TICK: begin
              now_d   = now_q + 1'b1;
              state_d = ST_DONE;
            end
            OP_LOOKUP: state_d = ST_LOOKUP;
            OP_PUT:    state_d = full ? ST_SWEEP : ST_FIND;
            OP_INVAL:  state_d = ST_INVAL;
            OP_CLEAR:  state_d = ST_CLEAR;
            default:   state_d = ST_DONE;
          endcase
        end
      end

      ST_LOOKUP: begin
        if (evl_q) begin
          if (ev.match) begin
            state_d = ST_DONE;
            if (ev.expired) begin
              vram_we       = 1'b1;
              valid_count_d = valid_count_q - 1'b1;
              miss_cnt_d    = miss_cnt_q + 1'b1;
              purge_cnt_d   = purge_cnt_q + 1'b1;
            end else begin
              hit_cnt_d = hit_cnt_q + 1'b1;
              hit_d     = 1'b1;
              rev_out_d = dram_rdata[DW-1];
            end
          end else if (eval_last) begin
            miss_cnt_d = miss_cnt_q + 1'b1;
            state_d    = ST_DONE;
          end
        end
      end

      ST_SWEEP: begin
        if (evl_q) begin
          if (ev.valid && ev.expired) begin
            vram_we       = 1'b1;
            valid_count_d = valid_count_q - 1'b1;
            purge_cnt_d   = purge_cnt_q + 1'b1;
          end
          if (eval_last) begin
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (full) begin
          drop_d     = 1'b1;
          drop_cnt_d = drop_cnt_q + 1'b1;
          state_d    = ST_DONE;
        end else begin
          scan_d  = '0;
          evl_d   = 1'b0;
          state_d = ST_FIND;
        end
      end

      ST_FIND: begin
        if (evl_q) begin
          if (!ev.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_addr_d  = eval_addr_q;
          end
          if (ev.match) begin
            tgt_addr_d = eval_addr_q;
            tgt_new_d  = 1'b0;
            state_d    = ST_WRITE;
          end else if (eval_last) begin
            // A free slot exists since the count is below the limit.
            tgt_addr_d = free_found_q ? free_addr_q : eval_addr_q;
            tgt_new_d  = 1'b1;
            state_d    = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        vram_we    = 1'b1;
        vram_waddr = tgt_addr_q;
        vram_wdata = 1'b1;
        dram_we    = 1'b1;
        if (tgt_new_q) begin
          valid_count_d = valid_count_q + 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_INVAL: begin
        if (evl_q) begin
          if (ev.match) begin
            vram_we       = 1'b1;
            valid_count_d = valid_count_q - 1'b1;
            state_d       = ST_DONE;
          end else if (eval_last) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      scan_q        <= '0;
      evl_q         <= 1'b0;
      free_found_q  <= 1'b0;
      tgt_new_q     <= 1'b0;
      now_q         <= '0;
      valid_count_q <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      purge_cnt_q   <= '0;
      drop_cnt_q    <= '0;
      hit_q         <= 1'b0;
      rev_out_q     <= 1'b0;
      drop_q        <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      scan_q        <= scan_d;
      evl_q         <= evl_d;
      free_found_q  <= free_found_d;
      tgt_new_q     <= tgt_new_d;
      now_q         <= now_d;
      valid_count_q <= valid_count_d;
      hit_cnt_q     <= hit_cnt_d;
      miss_cnt_q    <= miss_cnt_d;
      purge_cnt_q   <= purge_cnt_d;
      drop_cnt_q    <= drop_cnt_d;
      hit_q         <= hit_d;
      rev_out_q     <= rev_out_d;
      drop_q        <= drop_d;
      out_vld_q     <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_addr_q <= eval_addr_d;
    free_addr_q <= free_addr_d;
    tgt_addr_q  <= tgt_addr_d;
    if (in_i.valid && in_i.ready) begin
      key_q    <= in_i.token_key;
      rev_in_q <= in_i.revoked_in;
    end
    if (out_load) begin
      out_hit_q       <= hit_q;
      out_rev_q       <= rev_out_q;
      out_drop_q      <= drop_q;
      out_count_q     <= COUNT_W'(valid_count_q);
      out_hit_tot_q   <= hit_cnt_q;
      out_miss_tot_q  <= miss_cnt_q;
      out_purge_tot_q <= purge_cnt_q;
      out_drop_tot_q  <= drop_cnt_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.revoked_out = out_rev_q;
  assign out_o.dropped     = out_drop_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.hit_total   = out_hit_tot_q;
  assign out_o.miss_total  = out_miss_tot_q;
  assign out_o.purge_total = out_purge_tot_q;
  assign out_o.drop_total  = out_drop_tot_q;

`ifndef ASSERT_OFF
  // A new slot is only taken while the table still has room.
  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && tgt_new_q) |-> (32'(valid_count_q) < 32'(ENTRIES)))
    else $error("insert into a full table");

  // Slots are marked valid only by the write step of a put.
  a_set_only_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vram_we && vram_wdata[0]) |-> (state_q == ST_WRITE))
    else $error("valid bit set outside the write step");

  // A clear leaves the table empty.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && scan_q == LAST_SLOT) |=> (valid_count_q == '0))
    else $error("entry count not zero after clear");

  // A result never reports both a hit and a dropped put.
  a_hit_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_hit_q && out_drop_q))
    else $error("hit and dropped both set");
`endif

endmodule

// ----- bench/tb_ttl_denylist_cache.sv -----
// ----------------------------------------------------------------------------
// tb_ttl_denylist_cache
// Drives tick, lookup, put, invalidate, clear and unused operation items into
// the denylist cache under random idling on both channels, and checks every
// result item against an in-bench shadow of the table, its clock and its
// statistics counters. Directed items cover the edge cases first: overwrite,
// a limit below the stored count, zero TTL, zero limit and the sweep on a
// full table. Random phases follow under changing TTL and limit settings.
// ----------------------------------------------------------------------------
module tb_ttl_denylist_cache;
  import tdc_pkg::*;

  localparam int TBL_ENTRIES   = 64;
  localparam int SETTLE_CYCLES = 2 * TBL_ENTRIES + 10;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_AT       = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int POOL_SIZE     = 80;

  // Codes that the block treats as no operation.
  localparam logic [OPCODE_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic [TTL_W-1:0] TTL_MAX = '1;
  localparam logic [CAP_W-1:0] CAP_MAX = '1;

  typedef struct packed {
    logic               hit;
    logic               revoked;
    logic               dropped;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  hit_total;
    logic [STAT_W-1:0]  miss_total;
    logic [STAT_W-1:0]  purge_total;
    logic [STAT_W-1:0]  drop_total;
  } verdict_t;

  // Shadow copy of the denylist table; it predicts one verdict per accepted
  // operation and holds them until the block reports.
  class denylist_shadow;
    bit [TTL_W-1:0]  ttl;
    bit [CAP_W-1:0]  cap;
    bit              slot_used [TBL_ENTRIES];
    bit [KEY_W-1:0]  slot_key  [TBL_ENTRIES];
    bit              slot_rev  [TBL_ENTRIES];
    bit [31:0]       slot_stamp[TBL_ENTRIES];
    bit [31:0]       now;
    int unsigned     used_count;
    bit [STAT_W-1:0] hits, misses, purges, drops;
    verdict_t        pending[$];
    int              errors;

    function new();
      ttl = TTL_RESET;
      cap = CAP_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      now        = '0;
      used_count = 0;
      hits       = '0;
      misses     = '0;
      purges     = '0;
      drops      = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_TTL) begin
        ttl = value[TTL_W-1:0];
      end else begin
        cap = value[CAP_W-1:0];
      end
    endfunction

    // Age is taken modulo the 32-bit clock, so a very old stamp can look young.
    function bit stale(int s);
      bit [31:0] age;
      age = now - slot_stamp[s];
      return age >= 32'(ttl);
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      foreach (slot_used[s]) if (slot_used[s] && slot_key[s] == key) return s;
      return -1;
    endfunction

    function void note_op(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key, logic rev);
      verdict_t    v;
      int          s;
      int unsigned lim;
      v   = '0;
      lim = (cap < TBL_ENTRIES) ? cap : TBL_ENTRIES;
      case (op)
        OP_TICK: now = now + 1;
        OP_LOOKUP: begin
          s = find_slot(key);
          if (s < 0) begin
            misses++;
          end else if (stale(s)) begin
            slot_used[s] = 1'b0;
            used_count--;
            misses++;
            purges++;
          end else begin
            hits++;
            v.hit     = 1'b1;
            v.revoked = slot_rev[s];
          end
        end
        OP_PUT: begin
          if (used_count >= lim) begin
            foreach (slot_used[i]) begin
              if (slot_used[i] && stale(i)) begin
                slot_used[i] = 1'b0;
                used_count--;
                purges++;
              end
            end
            if (used_count >= lim) begin
              drops++;
              v.dropped = 1'b1;
            end
          end
          if (!v.dropped) begin
            s = find_slot(key);
            if (s < 0) begin
              foreach (slot_used[i]) if (s < 0 && !slot_used[i]) s = i;
              if (s >= 0) begin
                slot_used[s] = 1'b1;
                slot_key[s]  = key;
                used_count++;
              end
            end
            if (s >= 0) begin
              slot_rev[s]   = rev;
              slot_stamp[s] = now;
            end
          end
        end
        OP_INVAL: begin
          s = find_slot(key);
          if (s >= 0) begin
            slot_used[s] = 1'b0;
            used_count--;
          end
        end
        OP_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          used_count = 0;
        end
        default: ;
      endcase
      v.entry_count = COUNT_W'(used_count);
      v.hit_total   = hits;
      v.miss_total  = misses;
      v.purge_total = purges;
      v.drop_total  = drops;
      pending.push_back(v);
    endfunction

    function int field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("result item arrived with no operation outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      errors += field_diff("hit", 64'(want.hit), 64'(got.hit));
      errors += field_diff("revoked_out", 64'(want.revoked), 64'(got.revoked));
      errors += field_diff("dropped", 64'(want.dropped), 64'(got.dropped));
      errors += field_diff("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      errors += field_diff("hit_total", 64'(want.hit_total), 64'(got.hit_total));
      errors += field_diff("miss_total", 64'(want.miss_total), 64'(got.miss_total));
      errors += field_diff("purge_total", 64'(want.purge_total), 64'(got.purge_total));
      errors += field_diff("drop_total", 64'(want.drop_total), 64'(got.drop_total));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tdc_in_if  op_if ();
  tdc_out_if res_if ();

  denylist_shadow sb;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  int results_seen = 0;
  int cycle_count  = 0;

  ttl_denylist_cache #(
    .ENTRIES  (TBL_ENTRIES),
    .TIME_BITS(32)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ttl_denylist_cache] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_verdict({res_if.hit, res_if.revoked_out, res_if.dropped, res_if.entry_count,
                        res_if.hit_total, res_if.miss_total, res_if.purge_total,
                        res_if.drop_total});
    end
  end

  // Result side: random stalls, plus one long hold that backs the block up.
  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle_en ? $urandom_range(0, 15) : 0;
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (res_if.valid !== 1'b1) @(posedge clk_i);
      results_seen++;
    end
  end

  // Valid stays high across back-to-back items; this task only drops it for a gap.
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic rev);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_if.valid      <= 1'b1;
    op_if.opcode     <= op;
    op_if.token_key  <= key;
    op_if.revoked_in <= rev;
    @(posedge clk_i);
    while (op_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_op(op, key, rev);
  endtask

  // Leaves psel high so that a second write can follow without a double drive.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic reconfigure(input logic [31:0] ttl, input logic [31:0] cap);
    op_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_TTL, ttl);
    write_reg(REG_CAP, cap);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [OPCODE_W-1:0] pick_op(int put_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      case ($urandom_range(0, 2))
        0:       return OP_SPARE5;
        1:       return OP_SPARE6;
        default: return OP_SPARE7;
      endcase
    end
    if (r < 6) return (put_pct < 60) ? OP_CLEAR : OP_PUT;
    if (r < 13) return OP_INVAL;
    if (r < 13 + put_pct) return OP_PUT;
    if (r < 13 + put_pct + (87 - put_pct) / 2) return OP_LOOKUP;
    return OP_TICK;
  endfunction

  // Mostly keys from a pool so that lookups and overwrites find them.
  function automatic logic [KEY_W-1:0] pick_key(int span);
    if ($urandom_range(0, 99) < 10) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  initial begin : stimulus
    int          put_pct;
    int          span;
    int          n_items;
    logic [31:0] ttl_pick;
    logic [31:0] cap_pick;
    rst_ni           <= 1'b0;
    op_if.valid      <= 1'b0;
    op_if.opcode     <= OP_TICK;
    op_if.token_key  <= '0;
    op_if.revoked_in <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: miss, insert, overwrite, absent and present invalidate, unused codes, a tick.
    send_op(OP_LOOKUP, key_pool[0], 1'b0);
    send_op(OP_PUT, key_pool[0], 1'b1);
    send_op(OP_PUT, key_pool[1], 1'b0);
    send_op(OP_LOOKUP, key_pool[0], 1'b0);
    send_op(OP_PUT, key_pool[0], 1'b0);
    send_op(OP_LOOKUP, key_pool[0], 1'b1);
    send_op(OP_INVAL, key_pool[2], 1'b0);
    send_op(OP_INVAL, key_pool[1], 1'b1);
    send_op(OP_SPARE5, key_pool[1], 1'b1);
    send_op(OP_SPARE6, key_pool[3], 1'b0);
    send_op(OP_SPARE7, key_pool[4], 1'b1);
    send_op(OP_TICK, key_pool[5], 1'b1);
    send_op(OP_PUT, key_pool[2], 1'b1);
    send_op(OP_PUT, key_pool[3], 1'b0);
    send_op(OP_PUT, key_pool[4], 1'b1);

    // Limit lowered below the stored count: puts stay refused until it drops.
    reconfigure(32'd1000, 32'd3);
    send_op(OP_PUT, key_pool[6], 1'b1);
    send_op(OP_INVAL, key_pool[3], 1'b0);
    send_op(OP_PUT, key_pool[6], 1'b1);
    send_op(OP_INVAL, key_pool[4], 1'b0);
    send_op(OP_PUT, key_pool[6], 1'b1);
    send_op(OP_CLEAR, key_pool[6], 1'b0);

    // Zero TTL with a limit above the table size, then a zero limit.
    reconfigure(32'd0, 32'(CAP_MAX));
    send_op(OP_PUT, key_pool[0], 1'b1);
    send_op(OP_LOOKUP, key_pool[0], 1'b0);
    reconfigure(32'd0, 32'd0);
    send_op(OP_PUT, key_pool[1], 1'b1);

    // Full table: refused while young, swept once the entries have aged.
    reconfigure(32'd2, 32'd2);
    send_op(OP_PUT, key_pool[0], 1'b0);
    send_op(OP_PUT, key_pool[1], 1'b1);
    send_op(OP_PUT, key_pool[2], 1'b1);
    send_op(OP_TICK, key_pool[0], 1'b0);
    send_op(OP_TICK, key_pool[0], 1'b0);
    send_op(OP_PUT, key_pool[2], 1'b1);
    send_op(OP_LOOKUP, key_pool[2], 1'b0);

    // The first random phase fills the whole table under the largest limit.
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        ttl_pick = 32'(TTL_MAX);
        cap_pick = 32'(CAP_MAX);
        put_pct  = 85;
        span     = POOL_SIZE;
        n_items  = 130;
      end else begin
        case ($urandom_range(0, 4))
          0:       ttl_pick = 32'd0;
          1:       ttl_pick = $urandom_range(1, 8);
          2:       ttl_pick = $urandom_range(9, 60);
          3:       ttl_pick = 32'(TTL_MAX);
          default: ttl_pick = $urandom & 32'h7fff_ffff;
        endcase
        case ($urandom_range(0, 4))
          0:       cap_pick = 32'd0;
          1:       cap_pick = $urandom_range(1, 8);
          2:       cap_pick = $urandom_range(9, 64);
          3:       cap_pick = $urandom_range(65, 127);
          default: cap_pick = 32'd64;
        endcase
        case ($urandom_range(0, 2))
          0:       span = 6;
          1:       span = 20;
          default: span = POOL_SIZE;
        endcase
        put_pct = 30;
        n_items = 70;
      end
      send_idle_en = (p == 0) || ($urandom_range(0, 2) != 0);
      recv_idle_en = (p == 0) || ($urandom_range(0, 2) != 0);
      reconfigure(ttl_pick, cap_pick);
      repeat (n_items) send_op(pick_op(put_pct), pick_key(span), 1'($urandom_range(0, 1)));
    end

    op_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ttl_denylist_cache] OK");
    end else begin
      $display("[ttl_denylist_cache] ERROR");
    end
    $finish;
  end

endmodule
